### rtl/udts_pkg.sv
// Package for the byte dot-product top-k search block.
// Shared types and constants; no dependencies.
package udts_pkg;
    localparam int MaxDim  = 256;
    localparam int MaxKeep = 64;
    localparam int ScoreW  = 24;
    localparam int IdW     = 32;
    localparam logic [ScoreW-1:0] ScoreMax = '1;

    typedef enum logic [1:0] {
        ACT_QUERY = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_DRAIN = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic CFG_VLEN = 1'b0;
    localparam logic CFG_KEEP = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic query_wr;   // store query byte, advance position
        logic data_acc;   // accumulate data byte, advance position
        logic scan_step;  // step weakest-entry scan
        logic scan_clear; // restart scan
        logic offer_apply;// apply offer after scan
        logic drain_emit; // remove weakest into output register
        logic drain_clear;// empty store at end of drain
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic row_done;   // row finished on this beat (offer pending)
        logic scan_done;  // scan over held entries finished
        logic empty;      // store holds nothing
        logic one_left;   // exactly one entry held
    } t_status;
endpackage

### rtl/udts_datapath.sv
// Datapath: query memory, multiply-accumulate, kept-pair store and scan.
// Depends on udts_pkg.
module udts_datapath #(
    parameter int MAX_DIM  = udts_pkg::MaxDim,
    parameter int MAX_KEEP = udts_pkg::MaxKeep,
    localparam int PW = $clog2(MAX_DIM + 1),
    localparam int KW = $clog2(MAX_KEEP + 1),
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int SW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [8:0]                  i_cfg_data,
    input  udts_pkg::t_cmd              i_cmd,
    input  logic [7:0]                  i_val,
    input  logic [udts_pkg::IdW-1:0]    i_id,
    output udts_pkg::t_status           o_status,
    output logic [udts_pkg::ScoreW-1:0] o_score,
    output logic [udts_pkg::IdW-1:0]    o_row_id
);
    logic [8:0] r_vlen;
    logic [6:0] r_keep;
    logic [PW-1:0] r_pos;
    logic [udts_pkg::ScoreW-1:0] r_acc;
    logic [7:0] r_query [MAX_DIM];
    logic [udts_pkg::ScoreW-1:0] r_scores [MAX_KEEP];
    logic [udts_pkg::IdW-1:0]    r_ids    [MAX_KEEP];
    logic [KW-1:0] r_count;
    logic [SW-1:0] r_idx, r_wk;
    logic [KW-1:0] r_scan;
    logic [udts_pkg::ScoreW-1:0] r_wk_s, r_rd_s, r_off_s;
    logic [udts_pkg::IdW-1:0]    r_wk_i, r_rd_i, r_off_i;
    logic r_rd_v;
    logic [7:0] r_q;
    logic [udts_pkg::ScoreW-1:0] r_top_s;
    logic [udts_pkg::IdW-1:0]    r_top_i;

    logic [PW:0] len_eff, keep_eff;
    logic last;
    logic [15:0] prod;
    logic [udts_pkg::ScoreW:0] sum;
    logic [udts_pkg::ScoreW-1:0] sat;
    logic rd_less;
    logic [KW-1:0] top;

    always_comb begin
        if (r_vlen == '0) len_eff = (PW+1)'(1);
        else if (32'(r_vlen) > MAX_DIM) len_eff = (PW+1)'(MAX_DIM);
        else len_eff = (PW+1)'(r_vlen);
        if (r_keep == '0) keep_eff = (PW+1)'(1);
        else if (32'(r_keep) > MAX_KEEP) keep_eff = (PW+1)'(MAX_KEEP);
        else keep_eff = (PW+1)'(r_keep);
        last = ((PW+1)'(r_pos) + 1'b1) >= len_eff;
        prod = r_q * i_val;
        sum  = {1'b0, r_acc} + (udts_pkg::ScoreW+1)'(prod);
        sat  = sum[udts_pkg::ScoreW] ? udts_pkg::ScoreMax : sum[udts_pkg::ScoreW-1:0];
        rd_less = (r_rd_s < r_wk_s) || (r_rd_s == r_wk_s && r_rd_i < r_wk_i);
        top = r_count - 1'b1;
    end

    // query byte registered ahead of use: the controller passes through S_FETCH after each beat
    always_ff @(posedge i_clk) begin
        r_q <= r_query[r_pos[AW-1:0]];
        if (i_cmd.query_wr && 32'(r_pos) < MAX_DIM) r_query[r_pos[AW-1:0]] <= i_val;
        r_rd_s <= r_scores[r_scan[SW-1:0]];
        r_rd_i <= r_ids[r_scan[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= 9'd128; r_keep <= 7'd10;
            r_pos <= '0; r_acc <= '0; r_count <= '0;
            r_idx <= '0; r_scan <= '0; r_rd_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == udts_pkg::CFG_VLEN) r_vlen <= i_cfg_data;
                else r_keep <= i_cfg_data[6:0];
            end
            if (i_cmd.query_wr) begin
                r_acc <= '0;
                r_pos <= last ? '0 : r_pos + 1'b1;
            end
            if (i_cmd.data_acc) begin
                if (last) begin
                    r_acc <= '0; r_pos <= '0;
                    r_off_s <= sat; r_off_i <= i_id;
                end else begin
                    r_acc <= sat; r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.scan_clear) begin
                r_idx <= '0; r_scan <= '0; r_rd_v <= 1'b0;
                r_wk <= '0;
            end
            if (i_cmd.scan_step) begin
                // pipelined sweep: r_rd_* holds entry r_idx, read on the last step
                if (r_rd_v && (r_idx == '0 || rd_less)) begin
                    r_wk <= r_idx; r_wk_s <= r_rd_s; r_wk_i <= r_rd_i;
                end
                if (r_scan < r_count) begin
                    r_idx <= r_scan[SW-1:0]; r_scan <= r_scan + 1'b1;
                end
                r_rd_v <= (r_scan < r_count);
            end
            if (i_cmd.offer_apply) begin
                if ((PW+1)'(r_count) < keep_eff && 32'(r_count) < MAX_KEEP) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.drain_emit) r_count <= top;
            if (i_cmd.drain_clear) r_count <= '0;
        end
    end

    // store writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.offer_apply) begin
            if ((PW+1)'(r_count) < keep_eff && 32'(r_count) < MAX_KEEP) begin
                r_scores[r_count[SW-1:0]] <= r_off_s;
                r_ids[r_count[SW-1:0]]    <= r_off_i;
            end else if (r_count != '0 && r_off_s > r_wk_s) begin
                r_scores[r_wk] <= r_off_s;
                r_ids[r_wk]    <= r_off_i;
            end
        end else if (i_cmd.drain_emit) begin
            r_scores[r_wk] <= r_top_s;
            r_ids[r_wk]    <= r_top_i;
        end
        if (i_cmd.drain_emit) begin
            o_score <= r_wk_s; o_row_id <= r_wk_i;
        end
    end

    // last held entry, read alongside the scan for the drain move
    always_ff @(posedge i_clk) begin
        r_top_s <= r_scores[top[SW-1:0]];
        r_top_i <= r_ids[top[SW-1:0]];
    end

    assign o_status.row_done  = i_cmd.data_acc && last;
    assign o_status.scan_done = i_cmd.scan_step && !r_rd_v && (r_scan >= r_count);
    assign o_status.empty     = (r_count == '0);
    assign o_status.one_left  = (r_count == KW'(1));
endmodule

### rtl/udts_ctrl.sv
// Controller: sequences beats, top-k offer scan and drain output.
// Depends on udts_pkg.
module udts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_action,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_out_last,
    input  logic              i_out_ready,
    output udts_pkg::t_cmd    o_cmd,
    input  udts_pkg::t_status i_status
);
    typedef enum logic [2:0] {
        S_FETCH, S_IDLE, S_OSCAN, S_OAPPLY, S_DSCAN, S_DEMIT, S_DOUT
    } t_state;
    t_state r_state;
    logic acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '0;
        if (acc) begin
            o_cmd.query_wr = (i_action == udts_pkg::ACT_QUERY);
            o_cmd.data_acc = (i_action == udts_pkg::ACT_DATA);
            o_cmd.scan_clear = 1'b1;
        end
        // fresh scan for the next drain beat
        if (r_state == S_DOUT && i_out_ready && !o_out_last) o_cmd.scan_clear = 1'b1;
        o_cmd.scan_step   = (r_state == S_OSCAN) || (r_state == S_DSCAN);
        o_cmd.offer_apply = (r_state == S_OAPPLY);
        o_cmd.drain_emit  = (r_state == S_DEMIT);
        o_cmd.drain_clear = (r_state == S_DOUT) && i_out_ready && o_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH; o_out_valid <= 1'b0; o_out_last <= 1'b0;
        end else begin
            unique case (r_state)
                S_FETCH: r_state <= S_IDLE;
                S_IDLE: if (acc) begin
                    if (i_status.row_done) r_state <= S_OSCAN;
                    else if (i_action == udts_pkg::ACT_DRAIN && !i_status.empty)
                        r_state <= S_DSCAN;
                    else r_state <= S_FETCH;
                end
                S_OSCAN:  if (i_status.scan_done) r_state <= S_OAPPLY;
                S_OAPPLY: r_state <= S_FETCH;
                S_DSCAN:  if (i_status.scan_done) r_state <= S_DEMIT;
                S_DEMIT: begin
                    o_out_valid <= 1'b1; o_out_last <= i_status.one_left;
                    r_state <= S_DOUT;
                end
                S_DOUT: if (i_out_ready) begin
                    o_out_valid <= 1'b0;
                    r_state <= o_out_last ? S_FETCH : S_DSCAN;
                end
                default: r_state <= S_FETCH;
            endcase
        end
    end

    a_out_only_dout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_DOUT) else $error("out valid outside DOUT");
    a_ready_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result held");
    a_apply_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OAPPLY |-> $past(r_state) == S_OSCAN) else $error("bad apply");
endmodule

### rtl/uint8_dot_topk_search_top.sv
// Top level of the byte dot-product top-k search block.
// Instantiates udts_ctrl and udts_datapath; uses udts_pkg.
//
// Usage: slave channel beats carry {row_ident, element_value} in tdata and
// the action code in tuser. Action 0 loads one query byte, 1 takes one byte
// of a data row, 2 drains the kept (score, id) pairs in ascending order.
// The master channel gives one beat per kept pair, tlast on the final one.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data, index 0 vector_length, 1
// keep_count; write only while idle.
// Each byte beat is followed by a query-memory fetch (S_FETCH) before the
// next beat is taken. A row's final byte also scans the kept store entry
// by entry for the weakest pair, applies the offer and then refetches the
// query byte.
// Drain: the first beat is valid after a scan of the held pairs and the
// emit step; each further beat follows, by a new scan and emit, only after
// the previous one is taken; a stalled master side holds its beat and the
// block takes no input meanwhile.
// Reset (synchronous, active low) empties the store, zeroes position and
// accumulator and sets the registers to 128 and 10.
module uint8_dot_topk_search_top #(
    parameter int MAX_DIM  = udts_pkg::MaxDim,
    parameter int MAX_KEEP = udts_pkg::MaxKeep
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // element_value[7:0], row_ident[39:8]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // score[23:0], row_id[55:24]
    output logic        m_axis_tlast   // last_result
);
    udts_pkg::t_cmd    cmd;
    udts_pkg::t_status status;
    logic [23:0] score;
    logic [31:0] row_id;

    udts_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_action(s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_out_last(m_axis_tlast),
        .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_status(status)
    );

    udts_datapath #(.MAX_DIM(MAX_DIM), .MAX_KEEP(MAX_KEEP)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd(cmd), .i_val(s_axis_tdata[7:0]), .i_id(s_axis_tdata[39:8]),
        .o_status(status), .o_score(score), .o_row_id(row_id)
    );

    assign m_axis_tdata = {row_id, score};
endmodule
